// File: rtl/dhsbu_pkg.sv
// Shared constants and types for the debug halt / step / breakpoint unit.
// No dependencies; used by debug_halt_step_breakpoint_unit.
package dhsbu_pkg;

	localparam int BP_SLOTS   = 64;
	localparam int CORE_COUNT = 16;
	localparam int PC_WIDTH   = 32;

	localparam int BP_IDX_W   = (BP_SLOTS > 1) ? $clog2(BP_SLOTS) : 1;
	localparam int CORE_IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

	localparam int BUDGET_W = 32;

	typedef enum logic [2:0] {
		REQ_PAUSE    = 3'd0,
		REQ_CONTINUE = 3'd1,
		REQ_STEP_ALL = 3'd2,
		REQ_STEP_CORE = 3'd3,
		REQ_ADD_BP   = 3'd4,
		REQ_DEL_BP   = 3'd5,
		REQ_CHECK    = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_STALL = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// File: rtl/debug_halt_step_breakpoint_unit.sv
// Debug halt unit: pause flag, step budgets and a (core, PC) breakpoint table.
// Depends on dhsbu_pkg.
// Path: request register, then result register, which drives the outputs.
// Throughput: one request per cycle while rsp_stall holds no result; the breakpoint
// compare and first-free search are combinational logic between those two registers.
// Reset: asynchronous, active low; starts paused, budgets zero, breakpoint table empty,
// debug disabled. Breakpoint core/PC contents are not reset.
module debug_halt_step_breakpoint_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [3:0]  core_index,
	input  logic [31:0] pc_value,
	input  logic [15:0] step_count,
	input  logic [5:0]  slot_index,
	input  logic        is_retry,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic        breakpoint_hit,
	output logic [5:0]  slot_given,
	output logic        paused_now
);

	localparam int BP_SLOTS   = dhsbu_pkg::BP_SLOTS;
	localparam int CORE_COUNT = dhsbu_pkg::CORE_COUNT;
	localparam int PC_WIDTH   = dhsbu_pkg::PC_WIDTH;
	localparam int BP_IDX_W   = dhsbu_pkg::BP_IDX_W;
	localparam int CORE_IDX_W = dhsbu_pkg::CORE_IDX_W;
	localparam int BUDGET_W   = dhsbu_pkg::BUDGET_W;

	// configuration
	logic debug_en_q;

	// state
	logic                  paused_q;
	logic [BUDGET_W-1:0]   global_q;
	logic [BUDGET_W-1:0]   core_steps_q [CORE_COUNT];
	logic [BP_SLOTS-1:0]   bp_valid_q;
	logic [3:0]            bp_core_q [BP_SLOTS];
	logic [PC_WIDTH-1:0]   bp_pc_q [BP_SLOTS];

	// request register
	logic        valid_s1;
	logic [2:0]  req_s1;
	logic [3:0]  core_s1;
	logic [31:0] pc_s1;
	logic [15:0] count_s1;
	logic [5:0]  slot_s1;
	logic        retry_s1;

	// result register
	logic        valid_s2;
	logic [1:0]  status_s2;
	logic        hit_s2;
	logic [5:0]  given_s2;
	logic        paused_s2;

	logic adv;
	logic proc;

	// next-state / result logic
	logic [PC_WIDTH-1:0]   pc_m;
	logic [CORE_IDX_W-1:0] core_idx;
	logic [BP_IDX_W-1:0]   slot_idx;
	logic                  core_ok;
	logic                  slot_ok;
	logic [BP_SLOTS-1:0]   hit_vec;
	logic                  match;
	logic [BP_IDX_W-1:0]   free_idx;
	logic                  free_found;
	logic [BUDGET_W-1:0]   own;
	logic [BUDGET_W-1:0]   global_sat;
	logic [BUDGET_W-1:0]   own_sat;

	logic                  paused_d;
	logic [BUDGET_W-1:0]   global_d;
	logic                  core_clr_all;
	logic                  core_we;
	logic [BUDGET_W-1:0]   core_d;
	logic                  bp_set;
	logic                  bp_clr;
	logic [1:0]            status_d;
	logic                  hit_d;
	logic [5:0]            given_d;

	function automatic logic [BUDGET_W-1:0] sat_add(input logic [BUDGET_W-1:0] budget,
		input logic [15:0] cnt);
		logic [BUDGET_W:0] sum;
		logic [15:0]       n;
		n   = (cnt == 16'd0) ? 16'd1 : cnt;
		sum = {1'b0, budget} + (BUDGET_W+1)'(n);
		return sum[BUDGET_W] ? {BUDGET_W{1'b1}} : sum[BUDGET_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debug_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			debug_en_q <= cfg_data;
		end
	end

	// handshake
	assign adv       = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign proc      = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1   <= req_type;
			core_s1  <= core_index;
			pc_s1    <= pc_value;
			count_s1 <= step_count;
			slot_s1  <= slot_index;
			retry_s1 <= is_retry;
		end
	end

	assign pc_m     = PC_WIDTH'(pc_s1);
	assign core_idx = CORE_IDX_W'(core_s1);
	assign slot_idx = BP_IDX_W'(slot_s1);
	assign core_ok  = 32'(core_s1) < CORE_COUNT;
	assign slot_ok  = 32'(slot_s1) < BP_SLOTS;

	always_comb begin
		for (int i = 0; i < BP_SLOTS; i++) begin
			hit_vec[i] = bp_valid_q[i] && (bp_core_q[i] == core_s1) && (bp_pc_q[i] == pc_m);
		end
	end
	assign match = |hit_vec;

	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = BP_SLOTS - 1; i >= 0; i--) begin
			if (!bp_valid_q[i]) begin
				free_idx   = BP_IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	assign own        = core_ok ? core_steps_q[core_idx] : '0;
	assign global_sat = sat_add(global_q, count_s1);
	assign own_sat    = sat_add(own, count_s1);

	always_comb begin
		paused_d     = paused_q;
		global_d     = global_q;
		core_clr_all = 1'b0;
		core_we      = 1'b0;
		core_d       = own;
		bp_set       = 1'b0;
		bp_clr       = 1'b0;
		status_d     = dhsbu_pkg::ST_DONE;
		hit_d        = 1'b0;
		given_d      = '0;
		case (req_s1)
			dhsbu_pkg::REQ_PAUSE: begin
				paused_d = 1'b1;
			end
			dhsbu_pkg::REQ_CONTINUE: begin
				paused_d     = 1'b0;
				global_d     = '0;
				core_clr_all = 1'b1;
			end
			dhsbu_pkg::REQ_STEP_ALL: begin
				paused_d = 1'b1;
				global_d = global_sat;
			end
			dhsbu_pkg::REQ_STEP_CORE: begin
				if (core_ok) begin
					paused_d = 1'b1;
					core_we  = 1'b1;
					core_d   = own_sat;
				end
			end
			dhsbu_pkg::REQ_ADD_BP: begin
				if (free_found) begin
					bp_set  = 1'b1;
					given_d = 6'(free_idx);
				end else begin
					status_d = dhsbu_pkg::ST_FULL;
				end
			end
			dhsbu_pkg::REQ_DEL_BP: begin
				bp_clr = slot_ok;
			end
			dhsbu_pkg::REQ_CHECK: begin
				if (debug_en_q) begin
					if (!retry_s1 && match) begin
						hit_d    = 1'b1;
						paused_d = 1'b1;
					end
					if (paused_d) begin
						if (own != '0) begin
							core_we = 1'b1;
							core_d  = own - BUDGET_W'(1);
						end else if (global_q != '0) begin
							global_d = global_q - BUDGET_W'(1);
						end else begin
							status_d = dhsbu_pkg::ST_STALL;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q   <= 1'b1;
			global_q   <= '0;
			bp_valid_q <= '0;
			for (int c = 0; c < CORE_COUNT; c++) begin
				core_steps_q[c] <= '0;
			end
		end else if (proc) begin
			paused_q <= paused_d;
			global_q <= global_d;
			if (core_clr_all) begin
				for (int c = 0; c < CORE_COUNT; c++) begin
					core_steps_q[c] <= '0;
				end
			end else if (core_we) begin
				core_steps_q[core_idx] <= core_d;
			end
			if (bp_set) begin
				bp_valid_q[free_idx] <= 1'b1;
			end
			if (bp_clr) begin
				bp_valid_q[slot_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && bp_set) begin
			bp_core_q[free_idx] <= core_s1;
			bp_pc_q[free_idx]   <= pc_m;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			status_s2 <= status_d;
			hit_s2    <= hit_d;
			given_s2  <= given_d;
			paused_s2 <= paused_d;
		end
	end

	assign rsp_valid      = valid_s2;
	assign status         = status_s2;
	assign breakpoint_hit = hit_s2;
	assign slot_given     = given_s2;
	assign paused_now     = paused_s2;

	a_continue_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (req_s1 == dhsbu_pkg::REQ_CONTINUE) |=> !paused_q && (global_q == '0))
		else $error("continue did not clear pause and global budget");

	a_step_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (req_s1 == dhsbu_pkg::REQ_STEP_ALL) |=> paused_q && (global_q != '0))
		else $error("step all did not pause or grant budget");

	a_hit_paused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && breakpoint_hit |-> paused_now && (status != dhsbu_pkg::ST_FULL))
		else $error("breakpoint hit without pause");

	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == dhsbu_pkg::ST_FULL) |-> (slot_given == '0) && !breakpoint_hit)
		else $error("full status with a slot given");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		proc && bp_set |=> bp_valid_q[$past(free_idx)])
		else $error("added breakpoint slot not valid");

endmodule
